FILE: rtl/core/tes_pkg.sv
// Shared constants and controller/datapath interface types for the tick event scheduler.
// No dependencies; imported by every module of the block.
package tes_pkg;

	localparam int MAX_PENDING = 16;
	localparam int DELAY_BITS  = 16;

	localparam int SLOT_W     = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
	localparam int CNT_W      = $clog2(MAX_PENDING + 1);
	localparam int ID_W       = 8;
	localparam int DELAY_W    = 16;
	localparam int PERIOD_W   = 16;
	localparam int TICK_W     = 32;
	localparam int DELAY_USE  = (DELAY_BITS < DELAY_W) ? DELAY_BITS : DELAY_W;
	localparam int IN_DATA_W  = ID_W + DELAY_W + PERIOD_W;
	localparam int OUT_RAW_W  = 1 + ID_W + TICK_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic MODE_SCHEDULE = 1'b0;
	localparam logic MODE_TICK     = 1'b1;
	localparam logic KIND_STATUS   = 1'b0;
	localparam logic KIND_FIRED    = 1'b1;
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_FULL   = 1'b1;

	typedef struct packed {
		logic sched_write;
		logic push_status;
		logic tick_start;
		logic scan_step;
		logic scan_end;
		logic rearm_step;
		logic flush_push;
		logic finish;
	} tes_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic fire;
		logic hold_valid;
		logic rearm_empty;
		logic rearm_done;
		logic out_free;
	} tes_status_t;

endpackage

FILE: rtl/core/tes_ctrl.sv
// Sequencing state machine of the tick event scheduler.
// Depends on tes_pkg; issues commands to tes_datapath and reads its status.
module tes_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 mode,
	output logic                 s_tready,
	input  tes_pkg::tes_status_t st,
	output tes_pkg::tes_cmd_t    cmd
);
	import tes_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCHED,
		ST_SCAN,
		ST_REARM,
		ST_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (mode == MODE_TICK) begin
						cmd.tick_start = 1'b1;
						state_d        = ST_SCAN;
					end else begin
						cmd.sched_write = 1'b1;
						state_d         = ST_SCHED;
					end
				end
			end
			ST_SCHED: begin
				if (st.out_free) begin
					cmd.push_status = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					cmd.scan_end = 1'b1;
					state_d      = st.rearm_empty ? ST_FLUSH : ST_REARM;
				end else if (!(st.fire && st.hold_valid && !st.out_free)) begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_REARM: begin
				if (st.rearm_done) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.rearm_step = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (!st.hold_valid) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (st.out_free) begin
					cmd.flush_push = 1'b1;
					cmd.finish     = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/tes_datapath.sv
// Slot pool, arrival list, tick counter and output register of the tick event scheduler.
// Depends on tes_pkg; driven by commands from tes_ctrl.
module tes_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tes_pkg::tes_cmd_t               cmd,
	output tes_pkg::tes_status_t            st,
	input  logic [tes_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tes_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast
);
	import tes_pkg::*;

	logic [ID_W-1:0]     in_id;
	logic [DELAY_W-1:0]  in_delay;
	logic [PERIOD_W-1:0] in_period;
	logic [TICK_W-1:0]   delay_ext;

	logic [MAX_PENDING-1:0] valid_q;
	logic [TICK_W-1:0]      due_q    [MAX_PENDING];
	logic [ID_W-1:0]        action_q [MAX_PENDING];
	logic [PERIOD_W-1:0]    period_q [MAX_PENDING];
	logic [SLOT_W-1:0]      order_q  [MAX_PENDING];
	logic [SLOT_W-1:0]      rearm_q  [MAX_PENDING];

	logic [TICK_W-1:0] tick_q;
	logic [CNT_W-1:0]  pending_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  nk_q;
	logic [CNT_W-1:0]  nr_q;
	logic              full_q;
	logic              hold_valid_q;
	logic [ID_W-1:0]   hold_id_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic              out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [TICK_W-1:0] out_tick_q;
	logic              out_last_q;

	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] scan_slot;
	logic [SLOT_W-1:0] i_idx;
	logic [SLOT_W-1:0] nk_idx;
	logic [SLOT_W-1:0] nr_idx;
	logic [SLOT_W-1:0] pend_idx;
	logic              scan_fire;
	logic              out_free;
	logic              scan_push;

	assign in_id     = s_tdata[ID_W-1:0];
	assign in_delay  = s_tdata[ID_W+DELAY_W-1:ID_W];
	assign in_period = s_tdata[IN_DATA_W-1:ID_W+DELAY_W];
	assign delay_ext = {{(TICK_W-DELAY_USE){1'b0}}, in_delay[DELAY_USE-1:0]};

	assign i_idx     = i_q[SLOT_W-1:0];
	assign nk_idx    = nk_q[SLOT_W-1:0];
	assign nr_idx    = nr_q[SLOT_W-1:0];
	assign pend_idx  = pending_q[SLOT_W-1:0];
	assign scan_slot = order_q[i_idx];
	assign scan_fire = valid_q[scan_slot] && (due_q[scan_slot] == tick_q);
	assign out_free  = !out_valid_q || m_tready;
	assign scan_push = cmd.scan_step && scan_fire && hold_valid_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = MAX_PENDING - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(k);
			end
		end
	end

	always_comb begin
		st.scan_done   = (i_q == pending_q);
		st.fire        = scan_fire;
		st.hold_valid  = hold_valid_q;
		st.rearm_empty = (nr_q == '0);
		st.rearm_done  = (i_q == nr_q);
		st.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			tick_q       <= '0;
			pending_q    <= '0;
			i_q          <= '0;
			nk_q         <= '0;
			nr_q         <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.sched_write && free_found) begin
				valid_q[free_idx] <= 1'b1;
				pending_q         <= pending_q + CNT_W'(1);
			end
			if (cmd.tick_start) begin
				i_q          <= '0;
				nk_q         <= '0;
				nr_q         <= '0;
				hold_valid_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				i_q <= i_q + CNT_W'(1);
				if (valid_q[scan_slot]) begin
					if (!scan_fire) begin
						nk_q <= nk_q + CNT_W'(1);
					end else begin
						hold_valid_q <= 1'b1;
						if (period_q[scan_slot] == '0) begin
							valid_q[scan_slot] <= 1'b0;
						end else begin
							nr_q <= nr_q + CNT_W'(1);
						end
					end
				end
			end
			if (cmd.scan_end) begin
				i_q <= '0;
			end
			if (cmd.rearm_step) begin
				i_q  <= i_q + CNT_W'(1);
				nk_q <= nk_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				tick_q       <= tick_q + TICK_W'(1);
				pending_q    <= nk_q;
				hold_valid_q <= 1'b0;
			end
			if (cmd.push_status || scan_push || cmd.flush_push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sched_write) begin
			full_q <= !free_found;
			if (free_found) begin
				due_q[free_idx]    <= tick_q + delay_ext;
				action_q[free_idx] <= in_id;
				period_q[free_idx] <= in_period;
				order_q[pend_idx]  <= free_idx;
			end
		end
		if (cmd.scan_step && valid_q[scan_slot]) begin
			if (!scan_fire) begin
				order_q[nk_idx] <= scan_slot;
			end else begin
				hold_id_q <= action_q[scan_slot];
				if (period_q[scan_slot] != '0) begin
					due_q[scan_slot] <= tick_q + {{(TICK_W-PERIOD_W){1'b0}}, period_q[scan_slot]};
					rearm_q[nr_idx]  <= scan_slot;
				end
			end
		end
		if (cmd.rearm_step) begin
			order_q[nk_idx] <= rearm_q[i_idx];
		end
		if (cmd.push_status) begin
			out_kind_q   <= KIND_STATUS;
			out_status_q <= full_q;
			out_id_q     <= '0;
			out_tick_q   <= '0;
			out_last_q   <= 1'b1;
		end else if (scan_push || cmd.flush_push) begin
			out_kind_q   <= KIND_FIRED;
			out_status_q <= STATUS_OK;
			out_id_q     <= hold_id_q;
			out_tick_q   <= tick_q;
			out_last_q   <= cmd.flush_push;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, out_tick_q, out_id_q, out_status_q};

`ifndef SYNTHESIS
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(MAX_PENDING))
		else $error("pending count exceeds the pool size");

	a_pool_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sched_write |-> ($countones(valid_q) == int'(pending_q)))
		else $error("valid slots disagree with the pending count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_status || scan_push || cmd.flush_push) |-> out_free)
		else $error("result register loaded while still occupied");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (nk_q + nr_q <= i_q))
		else $error("arrival list compaction overtook the scan");
`endif

endmodule

FILE: rtl/core/tick_event_scheduler_top.sv
// Top level of the tick event scheduler: handshake ports around controller and datapath.
// Depends on tes_pkg, tes_ctrl and tes_datapath.
//
// A schedule transfer (tuser 0) stores an action in a free slot of a sixteen-entry pool, if one
// is free, and answers with one status result. A tick transfer (tuser 1) walks the arrival list
// one entry per cycle while the scan is not stalled, emits every action due at the current count
// but the last, then copies re-armed entries to the end of the list one per cycle and emits the
// last due action marked by tlast. Input is taken only between items; a result waiting in the
// output register stalls the scan only when a further result must be emitted.
module tick_event_scheduler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tes_pkg::IN_DATA_W-1:0]   s_tdata,  // action_id, delay, period
	input  logic                            s_tuser,  // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tes_pkg::OUT_DATA_W-1:0]  m_tdata,  // status, fired_id, fire_tick, zero fill
	output logic                            m_tuser,  // kind
	output logic                            m_tlast
);
	import tes_pkg::*;

	tes_cmd_t    cmd;
	tes_status_t st;

	tes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tes_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
